### rtl/mod_power_of_two_ring_alu_macros.svh
// Assertion macros for the ring arithmetic unit checker.
`ifndef MOD_POWER_OF_TWO_RING_ALU_MACROS_SVH
`define MOD_POWER_OF_TWO_RING_ALU_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define RA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ring alu check failed");
// Next-cycle implication checked outside reset.
`define RA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ring alu check failed");
`endif

### rtl/rpa_pkg.sv
// Package: command codes, sizes and shared helpers of the ring arithmetic unit.
`default_nettype none
package rpa_pkg;
	localparam int unsigned MaxExp = 32;
	localparam int unsigned CntW = 6;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_NEG = 4'd3,
		CMD_DIV = 4'd4, CMD_INV = 4'd5, CMD_GCD = 4'd6, CMD_LCM = 4'd7,
		CMD_EXTGCD = 4'd8, CMD_MOD = 4'd9, CMD_INTDIV = 4'd10, CMD_DIVCMP = 4'd11,
		CMD_DIVIDES = 4'd12, CMD_UNITPART = 4'd13, CMD_FROMSIGNED = 4'd14,
		CMD_TOSIGNED = 4'd15
	} cmd_t;

	// Request to the shared divider: 64-bit numerator over 33-bit divisor.
	typedef struct packed {
		logic        go;
		logic [63:0] num;
		logic [32:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
		logic [32:0] rem;
	} div_rsp_t;

	// Count trailing zeros of a nonzero word (zero gives 0).
	function automatic logic [CntW-1:0] ctz(input logic [31:0] x);
		logic [CntW-1:0] n;
		logic            hit;
		n = '0;
		hit = 1'b0;
		for (int i = 0; i < 32; i++) begin
			if (!hit && x[i]) begin
				n = CntW'(i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction
endpackage
`default_nettype wire

### rtl/rpa_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module rpa_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  rpa_pkg::div_req_t  req,
	output rpa_pkg::div_rsp_t  rsp
);
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [32:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] trial;
	logic [33:0] shifted;

	// Shift in the next numerator bit and try to subtract.
	assign shifted = {rem_q, quo_q[63]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[32:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
	assign rsp.rem = rem_q;
endmodule
`default_nettype wire

### rtl/mod_power_of_two_ring_alu.sv
// Top level: command sequencer of the ring arithmetic unit.
//
// Usage: write modulus_exponent through cfg_we/cfg_wdata while idle (values
// below 2 act as 2, above 32 as 32). Raise start with command, operand_a,
// operand_b and signed_value while busy is low; the request is taken at that
// edge and busy rises. The single result appears on the result ports for one
// cycle, flagged by done; the receiver cannot stall it.
// After the accepting edge, add, sub, neg, gcd, lcm, mod, divcompare,
// unitpart, the signed conversions and any command that ends early on an
// error pass through ST_PREP and ST_DONE; mul adds ST_MUL (one registered
// 32x32 multiply); inverse, extgcd and div by an odd reduced divisor add
// ST_INV (six Newton steps of two multiplies each) before ST_MUL, where div
// takes one final multiply; intdiv, divides and div whose reduced divisor
// stays even wait in ST_DIVW on the shared restoring divider. Busy drops in
// the cycle that carries done, so a new request is taken only after the
// previous one is done. The multiplier and the divider are shared units.
// Reset clears the sequencer, the done strobe and sets the exponent to 2.
`default_nettype none
module mod_power_of_two_ring_alu (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [5:0]         cfg_wdata,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [3:0]         command,
	input  wire logic [31:0]        operand_a,
	input  wire logic [31:0]        operand_b,
	input  wire logic signed [31:0] signed_value,
	output logic                    done,
	output logic [31:0]             result,
	output logic signed [32:0]      signed_result,
	output logic [31:0]             cofactor,
	output logic                    cofactor_for_b,
	output logic                    truth,
	output logic [1:0]              compare_code,
	output logic                    error,
	output logic                    a_is_unit,
	output logic                    a_is_zero,
	output logic                    a_is_one,
	output logic                    a_is_minus_one,
	output logic                    a_greater_zero
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_INV, ST_MUL, ST_DIVW, ST_DONE
	} state_t;

	state_t            state_q;
	logic [5:0]        exp_q;
	logic [5:0]        m_q;
	rpa_pkg::cmd_t     cmd_q;
	logic [31:0]       a_q, b_q, mask_q, x_q, y_q, inv_q, t_q;
	logic [31:0]       sv_q;
	logic [2:0]        it_q;
	logic              phase_q;
	logic              inv_go, div_go;
	rpa_pkg::div_req_t dreq;
	rpa_pkg::div_rsp_t drsp;
	logic [31:0]       res_q, cof_q;
	logic signed [32:0] sres_q;
	logic              forb_q, truth_q, err_q, done_q;
	logic [1:0]        code_q;
	logic [5:0]        m_eff;
	logic [32:0]       mod_w;
	logic [31:0]       mask_w;
	logic [63:0]       prod;
	logic [31:0]       mul_a, mul_b;
	logic [5:0]        ta, tb, tcom;
	logic [31:0]       xs, ys;

	// Clamp the exponent and derive modulus and mask.
	always_comb begin
		m_eff = exp_q;
		if (exp_q < 6'd2) m_eff = 6'd2;
		if (exp_q > 6'(rpa_pkg::MaxExp)) m_eff = 6'(rpa_pkg::MaxExp);
		mod_w = 33'd1 << m_eff;
		mask_w = 32'(mod_w - 33'd1);
	end

	// Trailing zero counts and common twos of the held operands.
	always_comb begin
		ta = rpa_pkg::ctz(a_q);
		tb = rpa_pkg::ctz(b_q);
		if (a_q == '0) tcom = tb;
		else if (b_q == '0) tcom = ta;
		else tcom = (ta < tb) ? ta : tb;
		xs = a_q >> tcom;
		ys = b_q >> tcom;
	end

	// Decide which shared unit the held request needs.
	always_comb begin
		inv_go = 1'b0;
		div_go = 1'b0;
		case (cmd_q)
			rpa_pkg::CMD_DIV: begin
				inv_go = (a_q != '0) && ys[0];
				div_go = (a_q != '0) && (b_q != '0) && !ys[0];
			end
			rpa_pkg::CMD_INV: inv_go = a_q[0];
			rpa_pkg::CMD_EXTGCD: inv_go = (a_q != '0) || (b_q != '0);
			rpa_pkg::CMD_INTDIV, rpa_pkg::CMD_DIVIDES: div_go = (b_q != '0);
			default: div_go = 1'b0;
		endcase
	end

	// Shared multiplier operands.
	assign prod = {32'd0, mul_a} * {32'd0, mul_b};

	rpa_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		dreq.go = 1'b0;
		dreq.num = '0;
		dreq.den = {1'b0, b_q};
		if (state_q == ST_PREP && div_go) begin
			dreq.go = 1'b1;
			if (cmd_q == rpa_pkg::CMD_DIV) begin
				dreq.num = {32'd0, xs};
				dreq.den = {1'b0, ys};
			end else if (a_q == '0) dreq.num = {31'd0, mod_w};
			else dreq.num = {32'd0, a_q};
		end
	end

	assign busy = (state_q != ST_IDLE);

	// Sequencer: holds state, the exponent and the done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			exp_q <= 6'd2;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) exp_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_PREP;
				ST_PREP: begin
					case (cmd_q)
						rpa_pkg::CMD_MUL: state_q <= ST_MUL;
						rpa_pkg::CMD_DIV, rpa_pkg::CMD_INV,
						rpa_pkg::CMD_EXTGCD:
							state_q <= inv_go ? ST_INV : (div_go ? ST_DIVW : ST_DONE);
						rpa_pkg::CMD_INTDIV, rpa_pkg::CMD_DIVIDES:
							state_q <= div_go ? ST_DIVW : ST_DONE;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_INV: if (it_q == 3'd5 && phase_q) state_q <= ST_MUL;
				ST_MUL: state_q <= ST_DONE;
				ST_DIVW: if (drsp.done) state_q <= ST_DONE;
				ST_DONE: begin
					state_q <= ST_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Multiplier operand select per state.
	always_comb begin
		mul_a = a_q;
		mul_b = b_q;
		if (state_q == ST_INV) begin
			if (!phase_q) begin
				mul_a = x_q; mul_b = inv_q;
			end else begin
				mul_a = inv_q; mul_b = 32'd2 - t_q;
			end
		end else if (state_q == ST_MUL && cmd_q == rpa_pkg::CMD_DIV) begin
			mul_a = y_q; mul_b = inv_q;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q <= rpa_pkg::cmd_t'(command);
					a_q <= operand_a & mask_w;
					b_q <= operand_b & mask_w;
					sv_q <= signed_value;
					mask_q <= mask_w;
					m_q <= m_eff;
				end
			end
			ST_PREP: begin
				res_q <= '0; sres_q <= '0; cof_q <= '0; forb_q <= 1'b0;
				truth_q <= 1'b0; code_q <= 2'd0; err_q <= 1'b0;
				it_q <= '0; phase_q <= 1'b0;
				case (cmd_q)
					rpa_pkg::CMD_ADD: res_q <= (a_q + b_q) & mask_q;
					rpa_pkg::CMD_SUB: res_q <= (a_q - b_q) & mask_q;
					rpa_pkg::CMD_NEG: res_q <= (32'd0 - a_q) & mask_q;
					rpa_pkg::CMD_DIV: begin
						// Cancel twos of an even nonzero divisor; an even rest goes to the divider.
						if (a_q != '0) begin
							if (b_q != '0 && !b_q[0]) begin
								x_q <= ys; y_q <= xs; inv_q <= ys;
								if (!ys[0]) err_q <= 1'b1;
							end else if (b_q == '0) begin
								err_q <= 1'b1;
							end else begin
								x_q <= b_q; y_q <= a_q; inv_q <= b_q;
							end
						end
					end
					rpa_pkg::CMD_INV: begin
						if (!a_q[0]) err_q <= 1'b1;
						x_q <= a_q; inv_q <= a_q;
					end
					rpa_pkg::CMD_GCD: begin
						res_q <= (a_q == '0 && b_q == '0) ? 32'd1 :
						         (32'd1 << tcom) & mask_q;
					end
					rpa_pkg::CMD_LCM: begin
						res_q <= (32'd1 << ((a_q == '0 ? 6'd0 : ta) >
						          (b_q == '0 ? 6'd0 : tb) ? (a_q == '0 ? 6'd0 : ta) :
						          (b_q == '0 ? 6'd0 : tb))) & mask_q;
					end
					rpa_pkg::CMD_EXTGCD: begin
						if (a_q == '0 && b_q == '0) begin
							res_q <= 32'd1;
						end else begin
							res_q <= (32'd1 << tcom) & mask_q;
							forb_q <= ys[0];
							x_q <= ys[0] ? ys : xs;
							inv_q <= ys[0] ? ys : xs;
						end
					end
					rpa_pkg::CMD_MOD: begin
						if (b_q != '0) res_q <= a_q & ((32'd1 << tb) - 32'd1);
					end
					rpa_pkg::CMD_INTDIV: begin
						if (a_q == '0 && b_q == '0) res_q <= 32'd1;
						else if (b_q == '0) err_q <= 1'b1;
					end
					rpa_pkg::CMD_DIVCMP: begin
						if (a_q == '0 || b_q == '0) err_q <= 1'b1;
						else code_q <= (ta > tb) ? 2'd2 : (tb > ta) ? 2'd1 : 2'd0;
					end
					rpa_pkg::CMD_DIVIDES: if (b_q == '0) err_q <= 1'b1;
					rpa_pkg::CMD_UNITPART: res_q <= (a_q == '0) ? 32'd1 : a_q >> ta;
					rpa_pkg::CMD_FROMSIGNED: res_q <= sv_q & mask_q;
					rpa_pkg::CMD_TOSIGNED: begin
						sres_q <= ({1'b0, a_q} > (mod_w >> 1)) ?
						          $signed({1'b0, a_q} - (33'd1 << m_q)) :
						          $signed({1'b0, a_q});
					end
					default: res_q <= '0;
				endcase
			end
			ST_INV: begin
				// Newton step y = y*(2 - x*y), split over two multiplies.
				if (!phase_q) t_q <= prod[31:0];
				else begin
					inv_q <= prod[31:0];
					it_q <= it_q + 3'd1;
				end
				phase_q <= ~phase_q;
			end
			ST_MUL: begin
				case (cmd_q)
					rpa_pkg::CMD_MUL: res_q <= prod[31:0] & mask_q;
					rpa_pkg::CMD_DIV: res_q <= prod[31:0] & mask_q;
					rpa_pkg::CMD_INV: res_q <= inv_q & mask_q;
					rpa_pkg::CMD_EXTGCD: cof_q <= inv_q & mask_q;
					default: res_q <= res_q;
				endcase
			end
			ST_DIVW: begin
				if (drsp.done) begin
					if (cmd_q == rpa_pkg::CMD_INTDIV) begin
						if (!(a_q == '0 && b_q == 32'd1)) res_q <= drsp.quo[31:0] & mask_q;
					end else if (cmd_q == rpa_pkg::CMD_DIV) begin
						res_q <= drsp.quo[31:0] & mask_q;
					end else begin
						truth_q <= (drsp.rem == '0);
					end
				end
			end
			default: res_q <= res_q;
		endcase
	end

	// Drive the result ports.
	assign done = done_q;
	assign result = done_q ? res_q : '0;
	assign signed_result = done_q ? sres_q : '0;
	assign cofactor = done_q ? cof_q : '0;
	assign cofactor_for_b = done_q & forb_q;
	assign truth = done_q & truth_q;
	assign compare_code = done_q ? code_q : 2'd0;
	assign error = done_q & err_q;
	assign a_is_unit = a_q[0];
	assign a_is_zero = (a_q == '0);
	assign a_is_one = (a_q == 32'd1);
	assign a_is_minus_one = (a_q == mask_q);
	assign a_greater_zero = (a_q != '0) && ({1'b0, a_q} <= ({1'b0, mask_q} + 33'd1) >> 1);
endmodule
`default_nettype wire

### rtl/rpa_checker.sv
// Port checker of the ring arithmetic unit, bound to the top level.
`default_nettype none
`include "mod_power_of_two_ring_alu_macros.svh"
module rpa_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic error,
	input wire logic truth,
	input wire logic a_is_zero,
	input wire logic a_is_unit
);
	`RA_ASSERT_NEXT(p_start_busy, clk, arst_n, start && !busy, busy)
	`RA_ASSERT_IMP(p_done_idle, clk, arst_n, done, !busy)
	`RA_ASSERT_NEXT(p_done_single, clk, arst_n, done, !done)
	`RA_ASSERT_IMP(p_flags_strobed, clk, arst_n, !done, !error && !truth)
	`RA_ASSERT_IMP(p_zero_even, clk, arst_n, done && a_is_zero, !a_is_unit)
endmodule
bind mod_power_of_two_ring_alu rpa_checker u_rpa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.error(error), .truth(truth), .a_is_zero(a_is_zero), .a_is_unit(a_is_unit)
);
`default_nettype wire
